>>> hw/rtl/delimited_frame_receiver_defines.svh
// Assertion macros shared by the frame receiver RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef DELIMITED_FRAME_RECEIVER_DEFINES_SVH
`define DELIMITED_FRAME_RECEIVER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define DFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define DFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/dfr_pkg.sv
// Shared types and constants for the delimited frame receiver.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dfr_pkg;

  localparam int unsigned DataW         = 8;
  localparam int unsigned FrameBytesDef = 64;

  localparam logic [DataW-1:0] StartCharRst = 8'h02;
  localparam logic [DataW-1:0] EndCharRst   = 8'hFF;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_START_CHAR = 1'b0,
    CFG_END_CHAR   = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    ST_COLLECT = 1'b0,
    ST_DRAIN   = 1'b1
  } rx_state_e;

  // One output beat.
  typedef struct packed {
    logic [DataW-1:0] msg_byte;
    logic             last;
  } out_beat_t;

  // Status of the output buffer, seen by the drain control.
  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } obuf_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/delimited_frame_receiver.sv
// Top level of the delimited frame receiver: collect control, frame RAM, output buffer.
// Depends on dfr_pkg, dfr_ram, dfr_obuf and delimited_frame_receiver_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "delimited_frame_receiver_defines.svh"

// Collects received bytes (one per slave beat) into a frame RAM of FRAME_BYTES entries, of
// which FRAME_BYTES-1 are usable. A byte equal to start_char restarts the frame and is kept
// as its first byte; any other byte except end_char is appended, and such a byte arriving when the
// frame already holds FRAME_BYTES-1 bytes is dropped and the frame restarts empty. When
// start_char and end_char match, that byte acts as end_char. An end_char beat on a non-empty
// frame releases the stored bytes on the master stream in received order, tlast on the final
// one; on an empty frame it does nothing. Timing: an ordinary byte leaves the slave side ready
// again right away. A closing byte on a non-empty frame holds tready low while the single RAM
// read port walks the frame; the first byte reaches the master side through the drain state,
// the registered RAM read and the output buffer, and the two-beat output buffer keeps reads
// going at one per cycle unless the master side stalls. Configuration writes are always taken
// (cfg_ready_o is tied high) and must only be made while the block is idle.
module delimited_frame_receiver #(
  parameter int unsigned FRAME_BYTES = dfr_pkg::FrameBytesDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Slave stream: tdata = rx_byte[7:0].
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire logic [dfr_pkg::DataW-1:0] s_axis_tdata_i,
  // Master stream: tdata = msg_byte[7:0]; tlast = last.
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  output logic      [dfr_pkg::DataW-1:0] m_axis_tdata_o,
  output logic                           m_axis_tlast_o,
  // Configuration write channel.
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [0:0]                cfg_index_i,
  input  wire logic [dfr_pkg::DataW-1:0] cfg_data_i
);
  import dfr_pkg::*;

  localparam int unsigned IdxW = $clog2(FRAME_BYTES);
  localparam logic [IdxW-1:0] FrameLast = IdxW'(FRAME_BYTES - 1);

  rx_state_e        state_q, state_d;
  logic [DataW-1:0] start_char_q, end_char_q;
  logic [IdxW-1:0]  fill_q, fill_d;
  logic [IdxW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [IdxW-1:0]  drain_last_q, drain_last_d;
  logic             rd_pend_q, rd_last_q;

  logic             in_beat;
  logic             is_end, is_start;
  logic [IdxW-1:0]  base_idx;
  logic             mem_we;
  logic             rd_en, rd_last;
  logic [DataW-1:0] mem_rdata;
  logic [2:0]       buf_after;
  obuf_stat_t       ob_stat;
  out_beat_t        ob_beat;
  out_beat_t        push_beat;

  assign cfg_ready_o = 1'b1;

  // Register writes; an index outside the list cannot be formed on a one-bit index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_char_q <= StartCharRst;
      end_char_q   <= EndCharRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_START_CHAR: start_char_q <= cfg_data_i;
        CFG_END_CHAR:   end_char_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_COLLECT);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign is_end          = (s_axis_tdata_i == end_char_q);
  assign is_start        = (s_axis_tdata_i == start_char_q);
  // A start byte rewinds to slot zero before it is stored.
  assign base_idx        = is_start ? '0 : fill_q;

  // Beats already buffered, plus the read in flight, minus the one leaving now.
  assign buf_after = {1'b0, ob_stat.count} + {2'b0, rd_pend_q} - {2'b0, ob_stat.pop};
  assign rd_last   = (rd_ptr_q == drain_last_q);

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    rd_ptr_d     = rd_ptr_q;
    drain_last_d = drain_last_q;
    mem_we       = 1'b0;
    rd_en        = 1'b0;
    unique case (state_q)
      ST_COLLECT: begin
        if (in_beat) begin
          if (is_end) begin
            // Release a non-empty frame; an empty one is left as is.
            if (fill_q != '0) begin
              state_d      = ST_DRAIN;
              rd_ptr_d     = '0;
              drain_last_d = fill_q - 1'b1;
              fill_d       = '0;
            end
          end else if (base_idx < FrameLast) begin
            mem_we = 1'b1;
            fill_d = base_idx + 1'b1;
          end else begin
            // Frame full: drop the byte and restart.
            fill_d = '0;
          end
        end
      end
      ST_DRAIN: begin
        // Issue a read only when the output buffer is sure to have room for it.
        if (buf_after < 3'd2) begin
          rd_en    = 1'b1;
          rd_ptr_d = rd_ptr_q + 1'b1;
          if (rd_last) begin
            state_d = ST_COLLECT;
          end
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      rd_ptr_q     <= '0;
      drain_last_q <= '0;
      rd_pend_q    <= 1'b0;
      rd_last_q    <= 1'b0;
    end else begin
      fill_q       <= fill_d;
      rd_ptr_q     <= rd_ptr_d;
      drain_last_q <= drain_last_d;
      rd_pend_q    <= rd_en;
      rd_last_q    <= rd_en && rd_last;
    end
  end

  // Frame store; writes and reads never share a cycle, so no forwarding is needed.
  dfr_ram #(
    .Width(DataW),
    .Depth(FRAME_BYTES)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(base_idx),
    .wdata_i(s_axis_tdata_i),
    .re_i   (rd_en),
    .raddr_i(rd_ptr_q),
    .rdata_o(mem_rdata)
  );

  assign push_beat.msg_byte = mem_rdata;
  assign push_beat.last     = rd_last_q;

  dfr_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (rd_pend_q),
    .push_beat_i(push_beat),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .beat_o     (ob_beat),
    .stat_o     (ob_stat)
  );

  assign m_axis_tdata_o = ob_beat.msg_byte;
  assign m_axis_tlast_o = ob_beat.last;

  `DFR_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= FrameLast, "fill index past last usable slot")
  `DFR_ASSERT_IMP(a_no_rw_clash, mem_we, !rd_en, "frame RAM written during drain")
  `DFR_ASSERT_NXT(a_drain_done, rd_en && rd_last, state_q == ST_COLLECT, "drain did not end")

endmodule

`default_nettype wire

>>> hw/rtl/dfr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/dfr_obuf.sv
// Two-entry output buffer between the frame RAM read port and the master stream.
// Depends on dfr_pkg and delimited_frame_receiver_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "delimited_frame_receiver_defines.svh"

module dfr_obuf (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire dfr_pkg::out_beat_t push_beat_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output dfr_pkg::out_beat_t      beat_o,
  output dfr_pkg::obuf_stat_t     stat_o
);
  import dfr_pkg::*;

  out_beat_t  slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign beat_o  = slot_q[rd_ptr_q];
  assign stat_o  = '{count: count_q, pop: pop};

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_beat_i;
    end
  end

  `DFR_ASSERT_IMP(a_no_overflow, push_i && !pop, count_q != 2'd2, "output buffer overflow")
  `DFR_ASSERT_IMP(a_count_range, 1'b1, count_q != 2'd3, "output buffer count out of range")
  `DFR_ASSERT_NXT(a_count_hold, !push_i && !pop, count_q == $past(count_q), "count moved idle")

endmodule

`default_nettype wire

>>> tb/tb.sv
// Testbench for delimited_frame_receiver: feeds received bytes on the slave stream, predicts
// the frames that each closing byte releases, and checks every master beat against them.
// Depends on dfr_pkg and the receiver RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb;
  import dfr_pkg::*;

  localparam int unsigned FrameBytes = FrameBytesDef;
  // Cycles to let pass once the last frame beat has shown up before touching the registers.
  localparam int unsigned DrainSlack = 4;
  // Cycles the sink holds off in the backpressure test; far longer than any drain.
  localparam int unsigned HoldCycles = 400;

  // Clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #6 clk_i = ~clk_i;

  // Slave stream: tdata = rx_byte[7:0].
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [DataW-1:0] s_axis_tdata_i  = '0;
  // Master stream: tdata = msg_byte[7:0]; tlast = last.
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [DataW-1:0] m_axis_tdata_o;
  logic             m_axis_tlast_o;
  // Configuration write channel.
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [0:0]       cfg_index_i = CFG_START_CHAR;
  logic [DataW-1:0] cfg_data_i  = '0;

  delimited_frame_receiver #(
    .FRAME_BYTES(FrameBytes)
  ) dut (
    .*
  );

  // ---------------------------------------------------------------------------------------
  // Frame predictor: its own copy of the delimiter registers and of the frame buffer.
  // ---------------------------------------------------------------------------------------
  logic [DataW-1:0] start_ch_m = StartCharRst;
  logic [DataW-1:0] end_ch_m   = EndCharRst;
  logic [DataW-1:0] frame_mem [FrameBytes];
  int unsigned      fill_cnt   = 0;

  // Beats still owed by the block, oldest first.
  out_beat_t frame_beats_q [$];

  int unsigned err_cnt  = 0;
  int unsigned sent_cnt = 0;

  // Advance the predicted frame by one accepted byte; queue the beats a closing byte releases.
  task automatic collect_byte(input logic [DataW-1:0] b);
    out_beat_t beat;
    // The end delimiter wins when both registers hold the same value.
    if (b == end_ch_m) begin
      if (fill_cnt != 0) begin
        for (int unsigned k = 0; k < fill_cnt; k++) begin
          beat.msg_byte = frame_mem[k];
          beat.last     = (k + 1 == fill_cnt);
          frame_beats_q.push_back(beat);
        end
        fill_cnt = 0;
      end
    end else begin
      // A start byte restarts the frame and is kept as its first byte.
      if (b == start_ch_m) fill_cnt = 0;
      // Only FrameBytes-1 slots are usable; one more byte drops and restarts the frame empty.
      if (fill_cnt < FrameBytes - 1) begin
        frame_mem[fill_cnt] = b;
        fill_cnt++;
      end else begin
        fill_cnt = 0;
      end
    end
  endtask

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("ERROR %0t: %s: got %0h, want %0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------------------
  // Sink side: stall on a rotating random pattern, or hold off for a long counted stretch
  // when a test asks for it.
  // ---------------------------------------------------------------------------------------
  bit          sink_stall_on = 1'b0;
  int unsigned sink_hold_req = 0;
  int unsigned hold_left     = 0;
  int unsigned pat_age       = 0;
  logic [15:0] ready_pat     = 16'hFFFF;

  always @(posedge clk_i) begin
    if (sink_hold_req != 0) begin
      hold_left     = sink_hold_req;
      sink_hold_req = 0;
    end
    // Refresh the pattern now and then; OR of two draws leaves it ready about 3/4 of the time.
    if (pat_age == 0) begin
      ready_pat = 16'($urandom | $urandom);
      pat_age   = 48;
    end else begin
      pat_age--;
    end
    ready_pat = {ready_pat[0], ready_pat[15:1]};
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= sink_stall_on ? ready_pat[0] : 1'b1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Beat checker: every accepted master beat must match the oldest predicted beat.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk_i) begin : beat_chk
    out_beat_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (frame_beats_q.size() == 0) begin
        report("beat with no frame byte pending", 32'(m_axis_tdata_o), 0);
      end else begin
        want = frame_beats_q.pop_front();
        if (m_axis_tdata_o !== want.msg_byte) begin
          report("msg_byte", 32'(m_axis_tdata_o), 32'(want.msg_byte));
        end
        if (m_axis_tlast_o !== want.last) begin
          report("tlast", 32'(m_axis_tlast_o), 32'(want.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Source side: send one byte, in bursts of random length with random gaps when enabled.
  // tvalid stays high between bytes of a burst, so it is never dropped and raised in one step.
  // ---------------------------------------------------------------------------------------
  bit          src_gaps_on = 1'b0;
  int unsigned burst_left  = 0;

  task automatic send_byte(input logic [DataW-1:0] b);
    if (src_gaps_on && burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left != 0) burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    collect_byte(b);
    sent_cnt++;
  endtask

  // Frame payload byte; steer clear of the delimiters except for wild_pct percent of draws.
  function automatic logic [DataW-1:0] body_byte(input int unsigned wild_pct);
    logic [DataW-1:0] b;
    b = 8'($urandom);
    if ($urandom_range(0, 99) >= wild_pct) begin
      while (b == start_ch_m || b == end_ch_m) b = 8'($urandom);
    end
    return b;
  endfunction

  // Start byte, n_body payload bytes, and the end byte when close is set.
  task automatic send_frame(input int unsigned n_body, input int unsigned wild_pct,
                            input bit close);
    send_byte(start_ch_m);
    repeat (n_body) send_byte(body_byte(wild_pct));
    if (close) send_byte(end_ch_m);
  endtask

  // Drop tvalid, wait for every owed beat, then let the block go quiet.
  task automatic settle();
    int unsigned guard;
    guard = 0;
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (frame_beats_q.size() != 0 && guard < 200_000) begin
      @(posedge clk_i);
      guard++;
    end
    if (frame_beats_q.size() != 0) begin
      report("frame beats never released", 0, frame_beats_q.size());
      frame_beats_q.delete();
    end
    repeat (DrainSlack) @(posedge clk_i);
  endtask

  // Register write; only called from an idle block.
  task automatic cfg_write(input cfg_reg_e idx, input logic [DataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_START_CHAR) start_ch_m = val;
    else end_ch_m = val;
    @(posedge clk_i);
  endtask

  task automatic set_delims(input logic [DataW-1:0] start_val, input logic [DataW-1:0] end_val);
    settle();
    cfg_write(CFG_START_CHAR, start_val);
    cfg_write(CFG_END_CHAR, end_val);
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Delimiters at their reset values; byte extremes, empty close, restart mid-frame.
  task automatic test_reset_values();
    logic [DataW-1:0] seq [] = '{8'hFF,                                    // close on empty
                                 8'h02, 8'h00, 8'h80, 8'h7F, 8'hFE, 8'hFF, // extremes
                                 8'h55, 8'hFF,                             // frame with no start
                                 8'h02, 8'h11, 8'h02, 8'h22, 8'hFF,        // restart mid-frame
                                 8'hFF};                                   // close twice
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Both registers at their extremes, swapped, and equal.
  task automatic test_register_extremes();
    set_delims(8'hFF, 8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'hAA);
    send_byte(8'h00);
    set_delims(8'h00, 8'hFF);
    send_byte(8'h00);
    send_byte(8'h55);
    send_byte(8'hFF);
    // Equal delimiters: the shared value closes the frame and never opens one.
    set_delims(8'h5A, 8'h5A);
    send_byte(8'h33);
    send_byte(8'h5A);
    send_byte(8'h5A);
  endtask

  // Full buffer: drop and restart, then a close on the emptied frame and a short frame.
  task automatic test_full_frame();
    set_delims(StartCharRst, EndCharRst);
    src_gaps_on   = 1'b1;
    sink_stall_on = 1'b1;
    send_frame(FrameBytes - 2, 0, 1'b0);
    send_byte(body_byte(0));
    send_byte(end_ch_m);
    send_frame(3, 0, 1'b1);
  endtask

  // Hold the sink off long enough for the output buffer to fill and the slave side to stall.
  task automatic test_backpressure();
    settle();
    src_gaps_on   = 1'b0;
    sink_stall_on = 1'b0;
    sink_hold_req = HoldCycles;
    send_frame(5, 0, 1'b1);
    send_frame(2, 0, 1'b1);
  endtask

  // Mostly well-formed frames with random content, plus noise, open frames and stray closes.
  task automatic test_random_traffic();
    int unsigned mark;
    int unsigned kind;
    int unsigned n_body;
    for (int phase = 0; phase < 2; phase++) begin
      kind = $urandom_range(0, 3);
      if (kind == 0) begin
        set_delims(8'($urandom), 8'($urandom));
      end else if (kind == 1) begin
        n_body = $urandom_range(0, 255);
        set_delims(8'(n_body), 8'(n_body));
      end else begin
        set_delims(8'($urandom), 8'($urandom));
      end
      src_gaps_on   = ($urandom_range(0, 3) != 0);
      sink_stall_on = ($urandom_range(0, 3) != 0);
      mark = sent_cnt;
      while (sent_cnt - mark < 10) begin
        kind   = $urandom_range(0, 9);
        n_body = $urandom_range(0, 5);
        if (kind <= 6) send_frame(n_body, 5, 1'b1);
        else if (kind == 7) send_byte(8'($urandom));
        else if (kind == 8) send_frame(n_body, 5, 1'b0);
        else send_byte(end_ch_m);
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequence: reset once, run the tests in turn, drain, and give the verdict.
  // ---------------------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_register_extremes();
    test_full_frame();
    test_backpressure();
    test_random_traffic();
    settle();
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, including every long sink stall.
  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
